/* rtl/pcs_pkg.sv */
`default_nettype none
package pcs_pkg;

    localparam int VISIT_BITS = 20;
    localparam int FRAC_BITS  = 16;
    localparam int LOSS_BITS  = 8;
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int EVAL_BITS  = VISIT_BITS + FRAC_BITS;
    localparam int PRIOR_BITS = FRAC_BITS + 1;
    localparam int VTOT_BITS  = 28;
    localparam int PTOT_BITS  = FRAC_BITS + 9;
    localparam int SCORE_BITS = FRAC_BITS + 9;
    localparam int OIDX_BITS  = 8;

    localparam int SQ_IN      = VTOT_BITS + FRAC_BITS;
    localparam int SQ_OUT     = SQ_IN / 2;
    localparam int RED_BITS   = GAIN_BITS + SQ_OUT - GAIN_FRAC;
    localparam int DEN_W      = VISIT_BITS + 1;
    localparam int EDV_NW     = EVAL_BITS + 1;
    localparam int GP_BITS    = GAIN_BITS + PRIOR_BITS;
    localparam int PROD_BITS  = GP_BITS + SQ_OUT;
    localparam int PDV_NW     = PROD_BITS - FRAC_BITS;
    localparam int VAL_W      = 48;

    localparam logic [1:0] CFG_PUCT_GAIN  = 2'd0;
    localparam logic [1:0] CFG_FPU_GAIN   = 2'd1;
    localparam logic [1:0] CFG_ROOT_NOISE = 2'd2;
    localparam logic [1:0] CFG_FPU_PARENT = 2'd3;

    typedef struct packed {
        logic [VISIT_BITS-1:0] visits;
        logic [LOSS_BITS-1:0]  loss;
        logic [EVAL_BITS-1:0]  total;
        logic [PRIOR_BITS-1:0] prior;
        logic [PRIOR_BITS-1:0] start;
        logic                  enabled;
    } t_rec;

endpackage
`default_nettype wire

/* rtl/puct_child_select_unit.sv */
`default_nettype none
// schedule: one child beat a cycle while a set loads; after the last beat the
// set-up runs two square roots and, when the fpu base needs it, one eval division,
// then each child is read in turn through the single read port of the child
// memory and each enabled child is scored through the bit-serial dividers
// throughput: input stalled from the last beat until the result is handed off
// reset: synchronous active low, clears the set and restores register defaults
module puct_child_select_unit
    import pcs_pkg::*;
#(
    parameter int MAX_CHILDREN = 256
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [3:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_side_is_defender,
    input  wire                         i_at_root,
    input  wire  [VISIT_BITS-1:0]       i_parent_own_visits,
    input  wire  [EVAL_BITS-1:0]        i_parent_eval_total,
    input  wire  [PRIOR_BITS-1:0]       i_parent_start_eval,
    input  wire  [VISIT_BITS-1:0]       i_child_visits,
    input  wire  [LOSS_BITS-1:0]        i_child_loss_count,
    input  wire  [EVAL_BITS-1:0]        i_child_eval_total,
    input  wire  [PRIOR_BITS-1:0]       i_child_prior,
    input  wire  [PRIOR_BITS-1:0]       i_child_start_eval,
    input  wire                         i_child_enabled,
    input  wire                         i_last_child,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [OIDX_BITS-1:0]        o_best_index,
    output logic signed [SCORE_BITS-1:0] o_best_score,
    output logic                        o_found
);

    localparam int IW    = $clog2(MAX_CHILDREN);
    localparam int CW    = $clog2(MAX_CHILDREN + 1);
    localparam int REC_W = $bits(t_rec);

    localparam logic signed [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] SCORE_MAX =
        {{(VAL_W-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SCORE_MIN =
        {{(VAL_W-SCORE_BITS+1){1'b1}}, {(SCORE_BITS-1){1'b0}}};

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SQV   = 4'd1;
    localparam logic [3:0] S_SQVW  = 4'd2;
    localparam logic [3:0] S_SQP   = 4'd3;
    localparam logic [3:0] S_SQPW  = 4'd4;
    localparam logic [3:0] S_RED   = 4'd5;
    localparam logic [3:0] S_BDIV  = 4'd6;
    localparam logic [3:0] S_BWAIT = 4'd7;
    localparam logic [3:0] S_BASE  = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_LAT   = 4'd10;
    localparam logic [3:0] S_MUL1  = 4'd11;
    localparam logic [3:0] S_MUL2  = 4'd12;
    localparam logic [3:0] S_PDIV  = 4'd13;
    localparam logic [3:0] S_WAIT  = 4'd14;
    localparam logic [3:0] S_CMP   = 4'd15;

    logic [3:0]            r_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [VTOT_BITS-1:0]  r_vtot;
    logic [PTOT_BITS-1:0]  r_ptot;
    logic                  r_fb_seen;
    logic                  r_found;
    logic                  r_ovalid;
    logic [GAIN_BITS-1:0]  r_puct_gain;
    logic [GAIN_BITS-1:0]  r_fpu_gain;
    logic                  r_noise;
    logic                  r_fpu_parent;

    logic [LOSS_BITS-1:0]  r_fb_loss;
    logic [EVAL_BITS-1:0]  r_fb_total;
    logic [PRIOR_BITS-1:0] r_fb_start;
    logic                  r_def;
    logic                  r_root;
    logic [VISIT_BITS-1:0] r_pv;
    logic [EVAL_BITS-1:0]  r_ptotal;
    logic [PRIOR_BITS-1:0] r_pstart;
    logic [SQ_OUT-1:0]     r_sq_v;
    logic [SQ_OUT-1:0]     r_sq_p;
    logic [RED_BITS-1:0]   r_red;
    logic                  r_bsel;
    logic                  r_badj;
    logic [PRIOR_BITS-1:0] r_braw;
    logic signed [VAL_W-1:0] r_base;
    t_rec                  r_rec;
    logic [GP_BITS-1:0]    r_gp;
    logic [PROD_BITS-1:0]  r_prod;
    logic signed [VAL_W-1:0] r_best_val;
    logic [IW-1:0]         r_best;
    logic [OIDX_BITS-1:0]  r_o_index;
    logic [SCORE_BITS-1:0] r_o_score;
    logic                  r_o_found;

    logic                  w_cfg_wr;
    logic                  w_in_acc;
    logic                  w_room;
    logic [VTOT_BITS:0]    w_vsum;
    logic [PTOT_BITS:0]    w_psum;
    logic [VTOT_BITS-1:0]  n_vtot;
    logic [PTOT_BITS-1:0]  n_ptot;
    t_rec                  w_rec;
    logic [REC_W-1:0]      w_rdata;

    logic                  sq_start;
    logic [SQ_IN-1:0]      sq_x;
    logic                  sq_busy;
    logic [SQ_OUT-1:0]     sq_root;

    logic                  edv_start;
    logic [EDV_NW-1:0]     edv_num;
    logic [DEN_W-1:0]      edv_den;
    logic                  edv_busy;
    logic [EDV_NW-1:0]     edv_q;
    logic                  pdv_start;
    logic [DEN_W-1:0]      pdv_den;
    logic                  pdv_busy;
    logic [PDV_NW-1:0]     pdv_q;

    logic                  w_bdiv;
    logic [GAIN_BITS+SQ_OUT-1:0] w_red_prod;
    logic [GP_BITS-1:0]    w_gp;
    logic [PROD_BITS-1:0]  w_prod;
    logic signed [VAL_W-1:0] w_braw;
    logic signed [VAL_W-1:0] w_beval;
    logic signed [VAL_W-1:0] w_cq;
    logic signed [VAL_W-1:0] w_win;
    logic signed [VAL_W-1:0] w_sum;
    logic signed [VAL_W-1:0] w_val;
    logic                  w_better;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            CFG_PUCT_GAIN:  prdata = 32'(r_puct_gain);
            CFG_FPU_GAIN:   prdata = 32'(r_fpu_gain);
            CFG_ROOT_NOISE: prdata = 32'(r_noise);
            CFG_FPU_PARENT: prdata = 32'(r_fpu_parent);
            default:        prdata = '0;
        endcase
    end

    assign o_stall  = (r_state != S_LOAD);
    assign w_in_acc = i_valid && !o_stall;
    assign w_room   = r_count < CW'(MAX_CHILDREN);

    assign w_rec.visits  = i_child_visits;
    assign w_rec.loss    = i_child_loss_count;
    assign w_rec.total   = i_child_eval_total;
    assign w_rec.prior   = i_child_prior;
    assign w_rec.start   = i_child_start_eval;
    assign w_rec.enabled = i_child_enabled;

    // running totals stop at full scale
    assign w_vsum = {1'b0, r_vtot} + (VTOT_BITS+1)'(i_child_visits);
    assign w_psum = {1'b0, r_ptot} + (PTOT_BITS+1)'(i_child_prior);
    assign n_vtot = w_vsum[VTOT_BITS] ? '1 : w_vsum[VTOT_BITS-1:0];
    assign n_ptot = w_psum[PTOT_BITS] ? '1 : w_psum[PTOT_BITS-1:0];

    pcs_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_CHILDREN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_room),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_rec),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign sq_start = (r_state == S_SQV) || (r_state == S_SQP);
    assign sq_x     = (r_state == S_SQV) ? {r_vtot, {FRAC_BITS{1'b0}}}
                                         : SQ_IN'({r_ptot, {FRAC_BITS{1'b0}}});

    pcs_sqrt #(
        .IN_W (SQ_IN)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // fpu base divides only by a nonzero parent visit or fallback loss count
    assign w_bdiv = r_fpu_parent ? (r_pv != '0) : (r_fb_seen && (r_fb_loss != '0));

    always_comb begin
        edv_start = 1'b0;
        edv_num   = EDV_NW'(r_rec.total)
                  + (r_def ? EDV_NW'({r_rec.loss, {FRAC_BITS{1'b0}}}) : '0);
        edv_den   = DEN_W'(r_rec.visits) + DEN_W'(r_rec.loss);
        if (r_state == S_BDIV) begin
            edv_start = w_bdiv;
            if (r_fpu_parent) begin
                edv_num = EDV_NW'(r_ptotal);
                edv_den = DEN_W'(r_pv);
            end else begin
                edv_num = EDV_NW'(r_fb_total)
                        + (r_def ? EDV_NW'({r_fb_loss, {FRAC_BITS{1'b0}}}) : '0);
                edv_den = DEN_W'(r_fb_loss);
            end
        end else if (r_state == S_MUL1) begin
            edv_start = r_rec.enabled;
        end
    end

    assign pdv_start = (r_state == S_PDIV);
    assign pdv_den   = DEN_W'(r_rec.visits) + DEN_W'(1);

    pcs_div #(
        .NW (EDV_NW),
        .DW (DEN_W)
    ) u_eval_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (edv_start),
        .i_num   (edv_num),
        .i_den   (edv_den),
        .o_busy  (edv_busy),
        .o_quot  (edv_q)
    );

    pcs_div #(
        .NW (PDV_NW),
        .DW (DEN_W)
    ) u_puct_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pdv_start),
        .i_num   (r_prod[PROD_BITS-1:FRAC_BITS]),
        .i_den   (pdv_den),
        .o_busy  (pdv_busy),
        .o_quot  (pdv_q)
    );

    assign w_red_prod = r_fpu_gain * r_sq_p;
    assign w_gp       = r_puct_gain * r_rec.prior;
    assign w_prod     = r_gp * r_sq_v;

    assign w_braw  = r_bsel ? VAL_W'(edv_q) : VAL_W'(r_braw);
    assign w_beval = (r_badj && r_def) ? (ONE_FX - w_braw) : w_braw;

    assign w_cq  = VAL_W'(edv_q);
    assign w_win = (r_rec.visits == '0) ? r_base
                 : (r_def ? (ONE_FX - w_cq) : w_cq);
    assign w_sum = w_win + VAL_W'(pdv_q);

    always_comb begin
        w_val = w_sum;
        if (w_sum > SCORE_MAX) begin
            w_val = SCORE_MAX;
        end else if (w_sum < SCORE_MIN) begin
            w_val = SCORE_MIN;
        end
    end

    assign w_better = !r_found || (w_val > r_best_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_idx        <= '0;
            r_vtot       <= '0;
            r_ptot       <= '0;
            r_fb_seen    <= 1'b0;
            r_found      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_puct_gain  <= GAIN_BITS'(256);
            r_fpu_gain   <= GAIN_BITS'(64);
            r_noise      <= 1'b0;
            r_fpu_parent <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    CFG_PUCT_GAIN:  r_puct_gain  <= pwdata[GAIN_BITS-1:0];
                    CFG_FPU_GAIN:   r_fpu_gain   <= pwdata[GAIN_BITS-1:0];
                    CFG_ROOT_NOISE: r_noise      <= pwdata[0];
                    CFG_FPU_PARENT: r_fpu_parent <= pwdata[0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_room) begin
                            r_count <= r_count + CW'(1);
                            r_vtot  <= n_vtot;
                            if (i_child_visits != '0) begin
                                r_ptot <= n_ptot;
                            end else begin
                                r_fb_seen <= 1'b1;
                            end
                        end
                        if (i_last_child) begin
                            r_state <= S_SQV;
                        end
                    end
                end
                S_SQV:  r_state <= S_SQVW;
                S_SQVW: if (!sq_busy) r_state <= S_SQP;
                S_SQP:  r_state <= S_SQPW;
                S_SQPW: if (!sq_busy) r_state <= S_RED;
                S_RED:  r_state <= S_BDIV;
                S_BDIV: r_state <= S_BWAIT;
                S_BWAIT: if (!edv_busy) r_state <= S_BASE;
                S_BASE: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_idx == r_count) begin
                        // scoring done: hand off the result once the output is free
                        if (!r_ovalid) begin
                            r_ovalid  <= 1'b1;
                            r_count   <= '0;
                            r_vtot    <= '0;
                            r_ptot    <= '0;
                            r_fb_seen <= 1'b0;
                            r_state   <= S_LOAD;
                        end
                    end else begin
                        r_state <= S_LAT;
                    end
                end
                S_LAT: r_state <= S_MUL1;
                S_MUL1: begin
                    if (!r_rec.enabled) begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: r_state <= S_PDIV;
                S_PDIV: r_state <= S_WAIT;
                S_WAIT: if (!edv_busy && !pdv_busy) r_state <= S_CMP;
                S_CMP: begin
                    if (w_better) begin
                        r_found <= 1'b1;
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_RD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && w_room && (i_child_visits == '0)) begin
                    r_fb_loss  <= i_child_loss_count;
                    r_fb_total <= i_child_eval_total;
                    r_fb_start <= i_child_start_eval;
                end
                if (w_in_acc && i_last_child) begin
                    r_def    <= i_side_is_defender;
                    r_root   <= i_at_root;
                    r_pv     <= i_parent_own_visits;
                    r_ptotal <= i_parent_eval_total;
                    r_pstart <= i_parent_start_eval;
                end
            end
            S_SQVW: if (!sq_busy) r_sq_v <= sq_root;
            S_SQPW: if (!sq_busy) r_sq_p <= sq_root;
            S_RED: begin
                r_red <= (!r_root || !r_noise)
                       ? w_red_prod[GAIN_BITS+SQ_OUT-1:GAIN_FRAC] : '0;
            end
            S_BDIV: begin
                r_bsel <= w_bdiv;
                r_badj <= r_fpu_parent || r_fb_seen;
                r_braw <= r_fpu_parent ? r_pstart : (r_fb_seen ? r_fb_start : '0);
            end
            S_BASE: r_base <= w_beval - VAL_W'(r_red);
            S_RD: begin
                if ((r_idx == r_count) && !r_ovalid) begin
                    r_o_found <= r_found;
                    r_o_index <= r_found ? OIDX_BITS'(r_best) : '0;
                    r_o_score <= r_found ? r_best_val[SCORE_BITS-1:0] : '0;
                end
            end
            S_LAT:  r_rec  <= t_rec'(w_rdata);
            S_MUL1: r_gp   <= w_gp;
            S_MUL2: r_prod <= w_prod;
            S_CMP: begin
                if (w_better) begin
                    r_best_val <= w_val;
                    r_best     <= r_idx[IW-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_best_index = r_o_index;
    assign o_best_score = r_o_score;
    assign o_found      = r_o_found;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CHILDREN))
        else $error("child count beyond memory depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAT) |-> (r_idx < r_count))
        else $error("scan read past the loaded set");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root restarted while busy");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(edv_start && edv_busy) && !(pdv_start && pdv_busy))
        else $error("divider restarted while busy");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_RD && r_state == S_LOAD) |->
            (r_count == '0 && r_vtot == '0 && r_ptot == '0 && o_valid))
        else $error("set not cleared on result hand-off");
`endif

endmodule
`default_nettype wire

/* rtl/pcs_ram.sv */
`default_nettype none
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/pcs_div.sv */
`default_nettype none
module pcs_div #(
    parameter int NW = 37,
    parameter int DW = 21
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [NW-1:0] i_num,
    input  wire  [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;
    logic          w_ge;

    // restoring, one quotient bit a cycle
    assign w_sh = {r_rem, r_q[NW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? DW'(w_sh - {1'b0, r_den}) : w_sh[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule
`default_nettype wire

/* rtl/pcs_sqrt.sv */
`default_nettype none
module pcs_sqrt #(
    parameter int IN_W = 44
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [IN_W-1:0]     i_x,
    output logic                o_busy,
    output logic [IN_W/2-1:0]   o_root
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;
    localparam int CW    = $clog2(OUT_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [IN_W-1:0]  r_x;
    logic [RW-1:0]    r_rem;
    logic [OUT_W-1:0] r_root;
    logic [RW-1:0]    w_sh;
    logic [RW-1:0]    w_trial;
    logic             w_ge;

    // one root bit a cycle
    assign w_sh    = {r_rem[RW-3:0], r_x[IN_W-1:IN_W-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = w_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(OUT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[IN_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_sh - w_trial) : w_sh;
            r_root <= {r_root[OUT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule
`default_nettype wire
